FILE: rtl/core/torb_pkg.sv
// Package for the time-ordered release buffer: sizes, status codes and cell types.
`default_nettype none
package torb_pkg;

    // Buffer geometry
    localparam int DEPTH        = 64;
    localparam int TIME_BITS    = 48;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);

    // Result status codes
    typedef enum logic [2:0] {
        ST_RELEASED = 3'd0,
        ST_NOT_DUE  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_INSERTED = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } t_cell_op;

    // Contents of one slot
    typedef struct packed {
        logic                    valid;
        logic [TIME_BITS-1:0]    key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    // Common control for the chain
    typedef struct packed {
        t_cell_op op;
        t_entry   new_entry;
    } t_chain_ctl;

endpackage
`default_nettype wire

FILE: rtl/core/torb_cell.sv
// One slot of the sorted chain: holds an entry and shifts on insert or pop.
`default_nettype none
module torb_cell
    import torb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_chain_ctl i_ctl,
    input  wire t_entry     i_left,     // neighbour nearer the head
    input  wire logic       i_left_gt,
    input  wire t_entry     i_right,    // neighbour nearer the tail
    output t_entry          o_entry,
    output logic            o_gt
);

    logic                    r_valid;
    logic [TIME_BITS-1:0]    r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    t_entry                  n_entry;

    // An empty slot counts as later than any new key
    assign o_gt = !r_valid || (r_key > i_ctl.new_entry.key);

    assign o_entry = '{valid: r_valid, key: r_key, payload: r_payload};

    // Next contents
    always_comb begin
        n_entry = o_entry;
        unique case (i_ctl.op)
            OP_INSERT: begin
                if (o_gt) begin
                    n_entry = i_left_gt ? i_left : i_ctl.new_entry;
                end
            end
            OP_POP:  n_entry = i_right;
            OP_HOLD: n_entry = o_entry;
            default: n_entry = o_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_key     <= n_entry.key;
        r_payload <= n_entry.payload;
    end

endmodule
`default_nettype wire

FILE: rtl/core/time_ordered_release_buffer_core.sv
// Top level of the time-ordered release buffer: command decode, cell chain and result register.
//
// Holds up to DEPTH entries (timestamp, payload handle) sorted earliest first in a chain
// of cells; equal timestamps keep arrival order. An item is taken when start is high and
// busy is low, one item per clock: every cell compares its key with the new key in parallel
// and the whole chain shifts together. The result appears in the cycle after acceptance on
// the o_ ports with o_strobe high for that single cycle; the receiver cannot stall it, so it
// must take every result. busy is high only in reset and in the cycle after reset is released.
`default_nettype none
module time_ordered_release_buffer_core
    import torb_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_mode,
    input  wire logic [TIME_BITS-1:0]    i_time_key,
    input  wire logic [PAYLOAD_BITS-1:0] i_payload,
    output logic                         o_strobe,
    output logic [2:0]                   o_status,
    output logic [TIME_BITS-1:0]         o_out_time,
    output logic [PAYLOAD_BITS-1:0]      o_out_payload,
    output logic [CNT_BITS-1:0]          o_occupancy
);

    logic                    r_busy;
    logic [CNT_BITS-1:0]     r_count;
    logic [CNT_BITS-1:0]     n_count;
    logic                    r_strobe;
    t_status                 r_status;
    t_status                 n_status;
    logic [TIME_BITS-1:0]    r_time;
    logic [TIME_BITS-1:0]    n_time;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [PAYLOAD_BITS-1:0] n_pay;

    logic       accept;
    logic       full;
    t_chain_ctl ctl;
    t_entry     cell_entry [DEPTH];
    logic       cell_gt    [DEPTH];
    logic [DEPTH-1:0] valid_vec;

    assign accept = start && !r_busy;
    assign full   = (r_count == CNT_BITS'(DEPTH));

    // Command decode against the head of the chain
    always_comb begin
        ctl.op        = OP_HOLD;
        ctl.new_entry = '{valid: 1'b1, key: i_time_key, payload: i_payload};
        n_count       = r_count;
        n_status      = ST_NOT_DUE;
        n_time        = '0;
        n_pay         = '0;
        if (!i_mode) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_INSERTED;
                n_count  = r_count + CNT_BITS'(1);
                ctl.op   = accept ? OP_INSERT : OP_HOLD;
            end
        end else begin
            priority if (!cell_entry[0].valid) begin
                n_status = ST_EMPTY;
            end else if (cell_entry[0].key < i_time_key) begin
                n_status = ST_RELEASED;
                n_time   = cell_entry[0].key;
                n_pay    = cell_entry[0].payload;
                n_count  = r_count - CNT_BITS'(1);
                ctl.op   = accept ? OP_POP : OP_HOLD;
            end else begin
                n_status = ST_NOT_DUE;
            end
        end
    end

    // Chain of cells, slot 0 holds the earliest entry
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry left_e;
        logic   left_gt;
        t_entry right_e;

        if (g == 0) begin : g_head
            assign left_e  = ctl.new_entry;
            assign left_gt = 1'b0;
        end else begin : g_mid
            assign left_e  = cell_entry[g-1];
            assign left_gt = cell_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_e = '{valid: 1'b0, key: '0, payload: '0};
        end else begin : g_body
            assign right_e = cell_entry[g+1];
        end

        torb_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_left    (left_e),
            .i_left_gt (left_gt),
            .i_right   (right_e),
            .o_entry   (cell_entry[g]),
            .o_gt      (cell_gt[g])
        );

        assign valid_vec[g] = cell_entry[g].valid;
    end

    // Count, busy and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_status <= n_status;
            r_time   <= n_time;
            r_pay    <= n_pay;
        end
    end

    assign busy          = r_busy;
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_out_time    = r_time;
    assign o_out_payload = r_pay;
    assign o_occupancy   = r_count;

    // Checks
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_BITS'($countones(valid_vec)))
        else $error("occupancy does not match valid cells");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_entry[0].valid && cell_entry[1].valid) |->
        (cell_entry[0].key <= cell_entry[1].key))
        else $error("head of chain out of order");

    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept))
        else $error("result without accepted item");

    a_release_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_RELEASED) |-> (o_out_time < $past(i_time_key)))
        else $error("released entry was not due");

endmodule
`default_nettype wire

FILE: tb/sv/torb_release_check_pkg.sv
// Scoreboard for the time-ordered release buffer: sorted-queue predictor and result checker.
`timescale 1ns / 1ps
package torb_release_check_pkg;
    import torb_pkg::*;

    // Command codes on i_mode
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FETCH  = 1'b1;

    // One predicted result
    typedef struct packed {
        t_status                 status;
        logic [TIME_BITS-1:0]    rel_time;
        logic [PAYLOAD_BITS-1:0] rel_payload;
        logic [CNT_BITS-1:0]     occupancy;
    } t_release_result;

    class release_scoreboard;
        // Held entries, earliest first
        logic [TIME_BITS-1:0]    held_keys[$];
        logic [PAYLOAD_BITS-1:0] held_payloads[$];
        // Results owed by the block, oldest first
        t_release_result         owed_results[$];
        int unsigned             errors;

        function new();
            errors = 0;
        endfunction

        // Apply one accepted item to the sorted queue and note the result it owes
        function void note_item(logic mode, logic [TIME_BITS-1:0] key,
                                logic [PAYLOAD_BITS-1:0] pay);
            t_release_result res;
            int              pos;
            res = '0;
            if (mode == MODE_INSERT) begin
                if (held_keys.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // after every held entry with a key not above the new one
                    pos = 0;
                    while (pos < held_keys.size() && held_keys[pos] <= key)
                        pos++;
                    held_keys.insert(pos, key);
                    held_payloads.insert(pos, pay);
                    res.status = ST_INSERTED;
                end
            end else begin
                if (held_keys.size() == 0) begin
                    res.status = ST_EMPTY;
                end else if (held_keys[0] < key) begin
                    res.rel_time    = held_keys.pop_front();
                    res.rel_payload = held_payloads.pop_front();
                    res.status      = ST_RELEASED;
                end else begin
                    res.status = ST_NOT_DUE;
                end
            end
            res.occupancy = CNT_BITS'(held_keys.size());
            owed_results.push_back(res);
        endfunction

        // Compare one result from the block with the oldest owed result
        function void check_result(logic [2:0] status, logic [TIME_BITS-1:0] rel_time,
                                   logic [PAYLOAD_BITS-1:0] rel_payload,
                                   logic [CNT_BITS-1:0] occupancy);
            t_release_result want;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d time %0h payload %0h",
                         $time, status, rel_time, rel_payload);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                errors++;
            end
            if (rel_time !== want.rel_time) begin
                $display("%0t: out_time expected %0h actual %0h",
                         $time, want.rel_time, rel_time);
                errors++;
            end
            if (rel_payload !== want.rel_payload) begin
                $display("%0t: out_payload expected %0h actual %0h",
                         $time, want.rel_payload, rel_payload);
                errors++;
            end
            if (occupancy !== want.occupancy) begin
                $display("%0t: occupancy expected %0d actual %0d",
                         $time, want.occupancy, occupancy);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Anything still owed at the end is a missing result
        function void flag_missing();
            while (owed_results.size() != 0) begin
                $display("%0t: missing result, status %0d expected",
                         $time, owed_results[0].status);
                void'(owed_results.pop_front());
                errors++;
            end
        endfunction
    endclass

endpackage

FILE: tb/sv/time_ordered_release_buffer_core_tb.sv
// Testbench top for the time-ordered release buffer core: stimulus, monitor and watchdog.
`timescale 1ns / 1ps
module time_ordered_release_buffer_core_tb;
    import torb_pkg::*;
    import torb_release_check_pkg::*;

    localparam int RANDOM_ITEMS = 1630;
    localparam int CALM_TAIL    = 300;   // last random items sent back to back
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_LIMIT  = 200;
    localparam logic [TIME_BITS-1:0] KEY_MAX = '1;

    // Key styles for a random phase
    localparam int KEYS_NARROW = 0;
    localparam int KEYS_WIDE   = 1;

    // Phase kinds: share of inserts
    localparam int PHASE_FILL  = 0;
    localparam int PHASE_DRAIN = 1;
    localparam int PHASE_MIXED = 2;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_mode;
    logic [TIME_BITS-1:0]    i_time_key;
    logic [PAYLOAD_BITS-1:0] i_payload;
    logic                    o_strobe;
    logic [2:0]              o_status;
    logic [TIME_BITS-1:0]    o_out_time;
    logic [PAYLOAD_BITS-1:0] o_out_payload;
    logic [CNT_BITS-1:0]     o_occupancy;

    release_scoreboard sb;
    int unsigned       stall_cycles = 0;

    time_ordered_release_buffer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_time_key    (i_time_key),
        .i_payload     (i_payload),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_out_time    (o_out_time),
        .o_out_payload (o_out_payload),
        .o_occupancy   (o_occupancy)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Offer one item and hold it until the block takes it
    task automatic send_item(input logic mode, input logic [TIME_BITS-1:0] key,
                             input logic [PAYLOAD_BITS-1:0] pay);
        start      <= 1'b1;
        i_mode     <= mode;
        i_time_key <= key;
        i_payload  <= pay;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        sb.note_item(mode, key, pay);
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [TIME_BITS-1:0] wide_key();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_BITS-1:0];
    endfunction

    // Timestamp or release time: near the phase base for narrow keys, random for wide keys, sometimes an extreme
    function automatic logic [TIME_BITS-1:0] pick_key(int style, logic [TIME_BITS-1:0] base);
        int roll;
        roll = $urandom_range(0, 63);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return KEY_MAX;
        if (style == KEYS_NARROW)
            return base + $urandom_range(0, 17);
        return wide_key();
    endfunction

    // Hand-picked items: empty fetches, extremes, ties and the not-due boundary
    task automatic run_directed();
        send_item(MODE_FETCH,  KEY_MAX,      32'h0000_0000);  // empty
        send_item(MODE_FETCH,  '0,           32'hFFFF_FFFF);  // empty
        send_item(MODE_INSERT, 48'd100,      32'hA5A5_A5A5);
        send_item(MODE_INSERT, 48'd100,      32'h0000_0001);  // tie
        send_item(MODE_INSERT, '0,           32'hFFFF_FFFF);
        send_item(MODE_INSERT, KEY_MAX,      32'h0000_0000);
        send_item(MODE_INSERT, 48'd100,      32'h0000_0002);  // tie
        send_item(MODE_FETCH,  '0,           32'h0000_0000);  // earliest equals release
        send_item(MODE_FETCH,  48'd1,        32'h0000_0000);  // releases key 0
        send_item(MODE_FETCH,  48'd100,      32'h0000_0000);  // not due
        send_item(MODE_FETCH,  48'd101,      32'h0000_0000);  // ties leave in arrival order
        send_item(MODE_FETCH,  48'd101,      32'h0000_0000);
        send_item(MODE_FETCH,  48'd101,      32'h0000_0000);
        send_item(MODE_FETCH,  KEY_MAX,      32'h0000_0000);  // max key never due
        send_item(MODE_INSERT, KEY_MAX - 1,  32'h5555_5555);
        send_item(MODE_FETCH,  KEY_MAX,      32'h0000_0000);
        send_item(MODE_FETCH,  KEY_MAX,      32'h0000_0000);
        send_item(MODE_INSERT, '0,           32'h0000_0003);
        send_item(MODE_FETCH,  KEY_MAX,      32'h0000_0000);
        send_item(MODE_FETCH,  48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    endtask

    // Phases that fill, drain or mix, with narrow or wide keys, to reach full and empty often
    task automatic run_random();
        int                   sent;
        int                   phase_len;
        int                   phase_kind;
        int                   key_style;
        int                   insert_pct;
        bit                   gappy;
        logic [TIME_BITS-1:0] base;
        logic                 mode;
        logic [TIME_BITS-1:0] key;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len  = $urandom_range(40, 140);
            phase_kind = $urandom_range(PHASE_FILL, PHASE_MIXED);
            key_style  = $urandom_range(KEYS_NARROW, KEYS_WIDE);
            gappy      = $urandom_range(0, 2) != 0;
            base       = wide_key() >> 1;
            case (phase_kind)
                PHASE_FILL:  insert_pct = 90;
                PHASE_DRAIN: insert_pct = 10;
                default:     insert_pct = 50;
            endcase
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_FETCH;
                if (mode == MODE_FETCH && phase_kind == PHASE_DRAIN && $urandom_range(0, 1))
                    key = KEY_MAX;
                else
                    key = pick_key(key_style, base);
                send_item(mode, key, $urandom);
                sent++;
                if (gappy && sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, 17));
            end
        end
    endtask

    // Monitor: every strobe is a result
    always @(posedge i_clk) begin
        if (o_strobe === 1'b1)
            sb.check_result(o_status, o_out_time, o_out_payload, o_occupancy);
    end

    // Watchdog: cycles in which neither an item nor a result moves
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main sequence
    initial begin
        int drain_cycles;
        sb           = new();
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_mode       = MODE_INSERT;
        i_time_key   = '0;
        i_payload    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        idle_for($urandom_range(1, 17));
        run_random();
        start <= 1'b0;

        // Let the last results come out
        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (4) @(posedge i_clk);
        sb.flag_missing();

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
